/* rtl/core/iterated_box_fir_smoother_defines.svh */
// ---------------------------------------------------------------------------
// Iterated box FIR smoother assertion macros
// Shared wrappers for the concurrent checks of the smoother.
// ---------------------------------------------------------------------------
`ifndef ITERATED_BOX_FIR_SMOOTHER_DEFINES_SVH
`define ITERATED_BOX_FIR_SMOOTHER_DEFINES_SVH

// Check sampled on the rising clock, muted while reset is asserted.
`define IBFS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ibfs: check failed");

// Check that also runs through reset.
`define IBFS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ibfs: check failed");

`endif

/* rtl/core/ibfs_pkg.sv */
// ---------------------------------------------------------------------------
// ibfs_pkg
// Sizes, controller states and the command/status bundles shared by the
// iterated box FIR smoother.
// ---------------------------------------------------------------------------
package ibfs_pkg;

    localparam int HORIZON   = 32;
    localparam int MAX_TAPS  = 64;
    localparam int SAMPLE_W  = 16;
    localparam int WEIGHT_W  = 16;
    localparam int HZ_AW     = $clog2(HORIZON);
    localparam int TAP_AW    = $clog2(MAX_TAPS);
    localparam int WIN_W     = 4;
    localparam int PASS_W    = 3;
    localparam int HALF_W    = WIN_W - 1;
    localparam int RAD_W     = TAP_AW - 1;
    localparam int DLY_DEPTH = 2**WIN_W - 1;
    localparam int PROD_W    = SAMPLE_W + WEIGHT_W + 1;
    localparam int ACC_W     = PROD_W + HZ_AW;
    localparam int WSUM_W    = WEIGHT_W + HZ_AW;
    localparam int NUM_W     = ACC_W + 1;
    localparam int DEN_W     = WSUM_W + 1;
    localparam int QUO_W     = SAMPLE_W + 1;
    localparam int QCNT_W    = $clog2(QUO_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PASSES = CFG_IDX_W'(1);

    localparam logic [HZ_AW-1:0]  HZ_LAST  = HZ_AW'(HORIZON - 1);
    localparam logic [TAP_AW-1:0] TAP_LAST = TAP_AW'(MAX_TAPS - 1);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_KBUILD,
        ST_KDRAIN,
        ST_MAC_SETUP,
        ST_MAC_ISSUE,
        ST_MAC_WAIT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              s_wr_en;
        logic [HZ_AW-1:0]  s_waddr;
        logic              s_rd_en;
        logic [HZ_AW-1:0]  s_raddr;
        logic              k_rd_en;
        logic [TAP_AW-1:0] k_raddr;
        logic              kb_valid;
        logic              kb_first_pass;
        logic [WIN_W-1:0]  box_w;
        logic              mac_valid;
        logic              mac_first;
        logic              mac_last;
        logic              mac_center;
        logic              div_start;
        logic              bypass;
        logic              out_load;
        logic              out_last;
    } cmd_t;

    typedef struct packed {
        logic acc_ready;
        logic res_ready;
        logic out_full;
    } sts_t;

    // Largest pass count whose kernel P*(W-1)+1 still fits the tap store.
    function automatic logic [PASS_W-1:0] pass_limit(input logic [HALF_W-1:0] half);
        int lim;
        case (half)
            3'd1:    lim = (MAX_TAPS - 1) / 2;
            3'd2:    lim = (MAX_TAPS - 1) / 4;
            3'd3:    lim = (MAX_TAPS - 1) / 6;
            3'd4:    lim = (MAX_TAPS - 1) / 8;
            3'd5:    lim = (MAX_TAPS - 1) / 10;
            3'd6:    lim = (MAX_TAPS - 1) / 12;
            3'd7:    lim = (MAX_TAPS - 1) / 14;
            default: lim = 0;
        endcase
        if (lim > 2**PASS_W - 1) begin
            lim = 2**PASS_W - 1;
        end
        return PASS_W'(lim);
    endfunction

endpackage

/* rtl/core/ibfs_div.sv */
// ---------------------------------------------------------------------------
// ibfs_div
// Restoring divider, one quotient bit per cycle, for the rounded mean.
// ---------------------------------------------------------------------------
module ibfs_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ibfs_pkg::NUM_W-1:0]   num,
    input  logic [ibfs_pkg::DEN_W-1:0]   den,
    output logic                         done,
    output logic [ibfs_pkg::QUO_W-1:0]   quo
);
    import ibfs_pkg::*;

    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              fits;

    assign fits = rem_reg >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            dsh_reg <= {{(NUM_W - DEN_W - QUO_W + 1){1'b0}}, den, {(QUO_W - 1){1'b0}}};
            quo_reg <= '0;
            cnt_reg <= QCNT_W'(QUO_W - 1);
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/core/ibfs_datapath.sv */
// ---------------------------------------------------------------------------
// ibfs_datapath
// Sample and tap stores, kernel builder, multiply-accumulate pipeline,
// rounding divide with saturation and the result register.
// ---------------------------------------------------------------------------
module ibfs_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ibfs_pkg::cmd_t                cmd,
    output ibfs_pkg::sts_t                sts,
    input  logic [ibfs_pkg::SAMPLE_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ibfs_pkg::SAMPLE_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import ibfs_pkg::*;

    localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'(2**(SAMPLE_W - 1) - 1);
    localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(2**(SAMPLE_W - 1));

    // Stores
    logic [SAMPLE_W-1:0] smem [HORIZON];
    logic [WEIGHT_W-1:0] kmem [MAX_TAPS];
    logic [SAMPLE_W-1:0] smem_q;
    logic [WEIGHT_W-1:0] kmem_q;

    // Kernel builder
    logic                kb_v1_reg;
    logic                kb_first1_reg;
    logic [TAP_AW-1:0]   kb_idx1_reg;
    logic [WEIGHT_W-1:0] run_reg;
    logic [WEIGHT_W-1:0] dly_reg [DLY_DEPTH];
    logic [WEIGHT_W-1:0] old_w;
    logic [WEIGHT_W-1:0] tail_w;
    logic [WEIGHT_W-1:0] run_base;
    logic [WEIGHT_W-1:0] run_sum;

    // Multiply-accumulate
    logic                       mac_v1_reg, mac_first1_reg, mac_last1_reg, mac_ctr1_reg;
    logic                       mac_v2_reg, mac_first2_reg, mac_last2_reg;
    logic signed [SAMPLE_W-1:0] smp_s;
    logic signed [WEIGHT_W:0]   wt_s;
    logic signed [PROD_W-1:0]   prod_c;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [WEIGHT_W-1:0]        wt2_reg;
    logic [SAMPLE_W-1:0]        cen_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [WSUM_W-1:0]          wsum_reg;
    logic                       acc_rdy_reg;

    // Divide and result
    logic               acc_neg;
    logic [ACC_W-1:0]   mag;
    logic [NUM_W-1:0]   num;
    logic [DEN_W-1:0]   den;
    logic               direct;
    logic               div_go;
    logic               div_done;
    logic [QUO_W-1:0]   quo;
    logic               neg_reg;
    logic [SAMPLE_W-1:0] sat_c;
    logic [SAMPLE_W-1:0] res_reg;
    logic               res_rdy_reg;

    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic                out_last_reg;

    // ---------------- stores ----------------
    always_ff @(posedge aclk) begin
        if (cmd.s_wr_en) begin
            smem[cmd.s_waddr] <= s_tdata;
        end
        if (cmd.s_rd_en) begin
            smem_q <= smem[cmd.s_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (kb_v1_reg) begin
            kmem[kb_idx1_reg] <= run_sum;
        end
        if (cmd.k_rd_en) begin
            kmem_q <= kmem[cmd.k_raddr];
        end
    end

    // ---------------- kernel builder ----------------
    // One box pass as a running sum: new[i] = new[i-1] + old[i] - old[i-W].
    always_comb begin
        if (kb_first1_reg) begin
            old_w = (kb_idx1_reg == '0) ? WEIGHT_W'(1) : '0;
        end else begin
            old_w = kmem_q;
        end
        if (TAP_AW'(cmd.box_w) <= kb_idx1_reg) begin
            tail_w = dly_reg[cmd.box_w - WIN_W'(1)];
        end else begin
            tail_w = '0;
        end
        run_base = (kb_idx1_reg == '0) ? '0 : run_reg;
        run_sum  = run_base + old_w - tail_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kb_v1_reg <= 1'b0;
        end else begin
            kb_v1_reg <= cmd.kb_valid;
        end
    end

    always_ff @(posedge aclk) begin
        kb_first1_reg <= cmd.kb_first_pass;
        kb_idx1_reg   <= cmd.k_raddr;
        if (kb_v1_reg) begin
            run_reg    <= run_sum;
            dly_reg[0] <= old_w;
            for (int j = 1; j < DLY_DEPTH; j++) begin
                dly_reg[j] <= dly_reg[j-1];
            end
        end
    end

    // ---------------- multiply-accumulate ----------------
    assign smp_s  = smem_q;
    assign wt_s   = {1'b0, kmem_q};
    assign prod_c = smp_s * wt_s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_v1_reg  <= 1'b0;
            mac_v2_reg  <= 1'b0;
            acc_rdy_reg <= 1'b0;
        end else begin
            mac_v1_reg  <= cmd.mac_valid;
            mac_v2_reg  <= mac_v1_reg;
            acc_rdy_reg <= mac_v2_reg && mac_last2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        mac_first1_reg <= cmd.mac_first;
        mac_last1_reg  <= cmd.mac_last;
        mac_ctr1_reg   <= cmd.mac_center;
        mac_first2_reg <= mac_first1_reg;
        mac_last2_reg  <= mac_last1_reg;
        if (mac_v1_reg) begin
            prod_reg <= prod_c;
            wt2_reg  <= kmem_q;
            if (mac_ctr1_reg) begin
                cen_reg <= smem_q;
            end
        end
        if (mac_v2_reg) begin
            acc_reg  <= (mac_first2_reg ? '0 : acc_reg)
                        + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            wsum_reg <= (mac_first2_reg ? '0 : wsum_reg) + {{HZ_AW{1'b0}}, wt2_reg};
        end
    end

    // ---------------- rounding divide ----------------
    // q = (2|acc| + wsum) / (2 wsum) rounds half away from zero.
    assign acc_neg = acc_reg[ACC_W-1];
    assign mag     = acc_neg ? (~acc_reg + ACC_W'(1)) : acc_reg;
    assign num     = {mag, 1'b0} + NUM_W'(wsum_reg);
    assign den     = {wsum_reg, 1'b0};
    assign direct  = cmd.bypass || (wsum_reg == '0);
    assign div_go  = cmd.div_start && !direct;

    ibfs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go),
        .num     (num),
        .den     (den),
        .done    (div_done),
        .quo     (quo)
    );

    always_comb begin
        if (neg_reg) begin
            if (quo > NEG_LIMIT) begin
                sat_c = {1'b1, {(SAMPLE_W - 1){1'b0}}};
            end else begin
                sat_c = SAMPLE_W'(~quo + QUO_W'(1));
            end
        end else begin
            if (quo > POS_LIMIT) begin
                sat_c = {1'b0, {(SAMPLE_W - 1){1'b1}}};
            end else begin
                sat_c = quo[SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_rdy_reg <= 1'b0;
        end else begin
            res_rdy_reg <= (cmd.div_start && direct) || div_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            neg_reg <= acc_neg;
            if (direct) begin
                res_reg <= cen_reg;
            end
        end else if (div_done) begin
            res_reg <= sat_c;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= res_reg;
            out_last_reg <= cmd.out_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign sts.acc_ready = acc_rdy_reg;
    assign sts.res_ready = res_rdy_reg;
    assign sts.out_full  = out_valid_reg && !m_tready;

endmodule

/* rtl/core/ibfs_ctrl.sv */
// ---------------------------------------------------------------------------
// ibfs_ctrl
// Configuration registers and the sequencer for loading, kernel build,
// per-output accumulation, divide and emission.
// ---------------------------------------------------------------------------
module ibfs_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ibfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ibfs_pkg::CFG_DATA_W-1:0] cfg_data,
    output ibfs_pkg::cmd_t                  cmd,
    input  ibfs_pkg::sts_t                  sts
);
    import ibfs_pkg::*;

    state_t              state_reg, state_next;
    logic [WIN_W-1:0]    win_reg, win_next;
    logic [PASS_W-1:0]   pcfg_reg, pcfg_next;
    logic [HZ_AW-1:0]    load_cnt_reg, load_cnt_next;
    logic                bypass_reg, bypass_next;
    logic [WIN_W-1:0]    boxw_reg, boxw_next;
    logic [PASS_W-1:0]   npass_reg, npass_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [PASS_W-1:0]   pidx_reg, pidx_next;
    logic [TAP_AW-1:0]   tap_reg, tap_next;
    logic [HZ_AW-1:0]    k_reg, k_next;
    logic [HZ_AW-1:0]    src_reg, src_next;

    logic [HALF_W-1:0]   half_c;
    logic                byp_c;
    logic [PASS_W-1:0]   plim_c;
    logic [PASS_W-1:0]   np_c;
    logic [TAP_AW-1:0]   rad6_c;
    logic [TAP_AW-1:0]   kx, rx, sum_hi, diff_lo;
    logic [HZ_AW-1:0]    lo_c, hi_c;
    logic [TAP_AW-1:0]   waddr_c;

    // Kernel shape from the live registers, latched when a horizon completes.
    assign half_c = win_reg[WIN_W-1:1];
    assign byp_c  = (half_c == '0) || (pcfg_reg == '0);
    assign plim_c = pass_limit(half_c);
    assign np_c   = (pcfg_reg > plim_c) ? plim_c : pcfg_reg;
    assign rad6_c = TAP_AW'(np_c) * TAP_AW'(half_c);

    // In-range span of the kernel around output k.
    assign kx      = TAP_AW'(k_reg);
    assign rx      = TAP_AW'(rad_reg);
    assign sum_hi  = kx + rx;
    assign diff_lo = kx - rx;
    assign lo_c    = (kx > rx) ? diff_lo[HZ_AW-1:0] : '0;
    assign hi_c    = (sum_hi > TAP_AW'(HZ_LAST)) ? HZ_LAST : sum_hi[HZ_AW-1:0];
    assign waddr_c = TAP_AW'(src_reg) + rx - kx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            win_reg      <= '0;
            pcfg_reg     <= '0;
            load_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            win_reg      <= win_next;
            pcfg_reg     <= pcfg_next;
            load_cnt_reg <= load_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        bypass_reg <= bypass_next;
        boxw_reg   <= boxw_next;
        npass_reg  <= npass_next;
        rad_reg    <= rad_next;
        pidx_reg   <= pidx_next;
        tap_reg    <= tap_next;
        k_reg      <= k_next;
        src_reg    <= src_next;
    end

    // Next state and counters
    always_comb begin
        state_next    = state_reg;
        win_next      = win_reg;
        pcfg_next     = pcfg_reg;
        load_cnt_next = load_cnt_reg;
        bypass_next   = bypass_reg;
        boxw_next     = boxw_reg;
        npass_next    = npass_reg;
        rad_next      = rad_reg;
        pidx_next     = pidx_reg;
        tap_next      = tap_reg;
        k_next        = k_reg;
        src_next      = src_reg;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_WINDOW: win_next  = cfg_data;
                CFG_PASSES: pcfg_next = cfg_data[PASS_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    if (load_cnt_reg == HZ_LAST) begin
                        load_cnt_next = '0;
                        bypass_next   = byp_c;
                        boxw_next     = {half_c, 1'b1};
                        npass_next    = np_c;
                        rad_next      = byp_c ? '0 : rad6_c[RAD_W-1:0];
                        k_next        = '0;
                        pidx_next     = '0;
                        tap_next      = '0;
                        state_next    = byp_c ? ST_MAC_SETUP : ST_KBUILD;
                    end else begin
                        load_cnt_next = load_cnt_reg + HZ_AW'(1);
                    end
                end
            end
            ST_KBUILD: begin
                if (tap_reg == TAP_LAST) begin
                    tap_next  = '0;
                    pidx_next = pidx_reg + PASS_W'(1);
                    if (pidx_reg == npass_reg - PASS_W'(1)) begin
                        state_next = ST_KDRAIN;
                    end
                end else begin
                    tap_next = tap_reg + TAP_AW'(1);
                end
            end
            ST_KDRAIN: begin
                state_next = ST_MAC_SETUP;
            end
            ST_MAC_SETUP: begin
                src_next   = lo_c;
                state_next = ST_MAC_ISSUE;
            end
            ST_MAC_ISSUE: begin
                src_next = src_reg + HZ_AW'(1);
                if (src_reg == hi_c) begin
                    state_next = ST_MAC_WAIT;
                end
            end
            ST_MAC_WAIT: begin
                if (sts.acc_ready) begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.res_ready) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!sts.out_full) begin
                    if (k_reg == HZ_LAST) begin
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_reg + HZ_AW'(1);
                        state_next = ST_MAC_SETUP;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Outputs
    always_comb begin
        cmd         = '0;
        cmd.s_waddr = load_cnt_reg;
        cmd.box_w   = boxw_reg;
        cmd.bypass  = bypass_reg;
        s_tready    = 1'b0;
        cfg_ready   = 1'b1;

        case (state_reg)
            ST_LOAD: begin
                s_tready    = 1'b1;
                cmd.s_wr_en = s_tvalid;
            end
            ST_KBUILD: begin
                cmd.k_rd_en       = 1'b1;
                cmd.k_raddr       = tap_reg;
                cmd.kb_valid      = 1'b1;
                cmd.kb_first_pass = (pidx_reg == '0);
            end
            ST_MAC_ISSUE: begin
                cmd.s_rd_en    = 1'b1;
                cmd.s_raddr    = src_reg;
                cmd.k_rd_en    = 1'b1;
                cmd.k_raddr    = waddr_c;
                cmd.mac_valid  = 1'b1;
                cmd.mac_first  = (src_reg == lo_c);
                cmd.mac_last   = (src_reg == hi_c);
                cmd.mac_center = (src_reg == k_reg);
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
            end
            ST_EMIT: begin
                cmd.out_load = !sts.out_full;
                cmd.out_last = (k_reg == HZ_LAST);
            end
            default: ;
        endcase
    end

endmodule

/* rtl/core/iterated_box_fir_smoother.sv */
// ---------------------------------------------------------------------------
// iterated_box_fir_smoother
// Top level: a horizon of 32 Q4.12 samples in, 32 smoothed samples out.
// ---------------------------------------------------------------------------
// Samples are taken one per cycle until the 32nd arrives; then the input
// stalls while the kernel (up to seven passes of a box of odd width) is
// rebuilt pass by pass over all 64 taps, and the 32 results follow, the
// last one flagged by tlast. Each result takes a setup step, one issue per
// in-range tap (at most 32) on the single multiply-accumulate unit, the
// read, product and accumulate registers, and the divider, which yields
// one quotient bit per cycle. With a width of 1 or no passes the kernel
// build is skipped and the result is the centre sample, with no divide.
// The input reopens as soon as the last result sits in the output
// register. Write configuration only while idle.
module iterated_box_fir_smoother (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ibfs_pkg::SAMPLE_W-1:0]   s_tdata,   // [15:0] raw_sample
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ibfs_pkg::SAMPLE_W-1:0]   m_tdata,   // [15:0] smoothed_sample
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ibfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ibfs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ibfs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ibfs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    ibfs_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/core/ibfs_checker.sv */
// ---------------------------------------------------------------------------
// ibfs_checker
// Port-level checks of the smoother, bound to the top level.
// ---------------------------------------------------------------------------
`include "iterated_box_fir_smoother_defines.svh"

module ibfs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ibfs_pkg::SAMPLE_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import ibfs_pkg::*;

    logic [HZ_AW-1:0] s_cnt_reg;
    logic [HZ_AW-1:0] m_cnt_reg;

    // Count transfers on both sides within the current horizon.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_cnt_reg <= '0;
            m_cnt_reg <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                s_cnt_reg <= (s_cnt_reg == HZ_LAST) ? '0 : s_cnt_reg + HZ_AW'(1);
            end
            if (m_tvalid && m_tready) begin
                m_cnt_reg <= (m_cnt_reg == HZ_LAST) ? '0 : m_cnt_reg + HZ_AW'(1);
            end
        end
    end

    `IBFS_ASSERT_ALWAYS(a_reset_empties_out, aclk, !aresetn |=> !m_tvalid)

    `IBFS_ASSERT(a_out_stall_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    `IBFS_ASSERT(a_tlast_on_final, aclk, aresetn, m_tvalid |-> (m_tlast == (m_cnt_reg == HZ_LAST)))

    `IBFS_ASSERT(a_busy_after_horizon, aclk, aresetn, s_tvalid && s_tready && (s_cnt_reg == HZ_LAST) |=> !s_tready)

endmodule

bind iterated_box_fir_smoother ibfs_checker u_checker (.*);
